// ----- sv/mbb_pkg.sv -----
`timescale 1ns / 1ps
package mbb_pkg;

  localparam int HEIGHT_BITS = 32;
  localparam int MAX_DETAIL  = 32;
  localparam int CW          = 6;
  localparam int SIDE        = MAX_DETAIL + 1;
  localparam int DEPTH       = SIDE * SIDE;
  localparam int AW          = $clog2(DEPTH);
  localparam int SUM_W       = HEIGHT_BITS + 4;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int PH_W        = 4;
  localparam int PH_LAST     = 9;

  // mean = floor(|sum| * RECIP / 2^DIV_SHIFT), then one fix-up step
  localparam int DIV_SHIFT = SUM_W;
  localparam int RECIP_W   = SUM_W - 3;
  localparam longint unsigned RECIP = (64'd1 << DIV_SHIFT) / 64'd9;

  localparam logic [CFG_IDX_W-1:0] REG_DETAIL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CROW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CCOL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AMOUNT = 3'd6;

  localparam logic [1:0] OFF_DEC  = 2'd0;
  localparam logic [1:0] OFF_SAME = 2'd1;
  localparam logic [1:0] OFF_INC  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RUN,
    ST_DIV,
    ST_FIX,
    ST_BLEND,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic accept;
    logic emit_start;
    logic ph_step;
    logic div;
    logic fix;
    logic blend;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic emit_ok;
    logic ph_last;
    logic last;
    logic out_full;
  } dp_status_t;

  // neighbor phase -> {row offset code, column offset code}
  function automatic logic [3:0] nbr_off(input logic [PH_W-1:0] ph);
    logic [3:0] r;
    case (ph)
      4'd0: r = {OFF_DEC, OFF_DEC};
      4'd1: r = {OFF_DEC, OFF_SAME};
      4'd2: r = {OFF_DEC, OFF_INC};
      4'd3: r = {OFF_SAME, OFF_DEC};
      4'd4: r = {OFF_SAME, OFF_SAME};
      4'd5: r = {OFF_SAME, OFF_INC};
      4'd6: r = {OFF_INC, OFF_DEC};
      4'd7: r = {OFF_INC, OFF_SAME};
      4'd8: r = {OFF_INC, OFF_INC};
      default: r = {OFF_SAME, OFF_SAME};
    endcase
    return r;
  endfunction

endpackage

// ----- sv/mbb_ctrl.sv -----
`timescale 1ns / 1ps
module mbb_ctrl import mbb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.emit_ok) begin
          cmd_o.emit_start = 1'b1;
          state_d          = ST_RUN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_RUN: begin
        cmd_o.ph_step = 1'b1;
        if (status_i.ph_last) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = ST_FIX;
      end
      ST_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = ST_BLEND;
      end
      ST_BLEND: begin
        cmd_o.blend = 1'b1;
        state_d     = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!status_i.out_full) begin
          cmd_o.advance = 1'b1;
          state_d       = status_i.last ? ST_IDLE : ST_CHECK;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- sv/mbb_dp.sv -----
`timescale 1ns / 1ps
module mbb_dp import mbb_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  input  logic [HEIGHT_BITS-1:0] height_in_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [HEIGHT_BITS-1:0] height_out_o,
  output logic [CW-1:0]          out_row_o,
  output logic [CW-1:0]          out_col_o,
  output logic                   sector_done_o,
  input  dp_cmd_t                cmd_i,
  output dp_status_t             status_o
);

  localparam int DR_W  = 19;
  localparam int SQ_W  = 34;
  localparam int S_W   = SQ_W + 1;
  localparam int P_W   = 64 + S_W;
  localparam int PL_W  = 32 + S_W;
  localparam int ST_W  = CW + 7;
  localparam int T_W   = HEIGHT_BITS + 18;
  localparam int MP_W  = SUM_W - 1 + RECIP_W;
  localparam logic [16:0] ONE = 17'd65536;

  // configuration
  logic [CW-1:0] detail_q;
  logic [16:0]   crow_q, ccol_q, amount_q;
  logic [2:0]    lod_q;
  logic [31:0]   vscale_q, radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detail_q <= CW'(MAX_DETAIL);
      crow_q   <= '0;
      ccol_q   <= '0;
      lod_q    <= '0;
      vscale_q <= 32'd65536;
      radius_q <= '0;
      amount_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DETAIL: detail_q <= cfg_data_i[CW-1:0];
        REG_CROW:   crow_q   <= cfg_data_i[16:0];
        REG_CCOL:   ccol_q   <= cfg_data_i[16:0];
        REG_LOD:    lod_q    <= cfg_data_i[2:0];
        REG_SCALE:  vscale_q <= cfg_data_i[31:0];
        REG_RADIUS: radius_q <= cfg_data_i[31:0];
        REG_AMOUNT: amount_q <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] d;
  logic [CW:0]   side;
  assign d = (detail_q == '0) ? CW'(1) :
             (detail_q > CW'(MAX_DETAIL)) ? CW'(MAX_DETAIL) : detail_q;
  assign side = {1'b0, d} + (CW+1)'(1);

  // counters
  logic [CW-1:0] in_row_q, in_col_q, emit_row_q, emit_col_q, got_row_q, got_col_q;
  logic          restart;
  logic          last;
  assign restart = cfg_we_i && (cfg_idx_i == REG_DETAIL);
  assign last    = (emit_row_q == d) && (emit_col_q == d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q   <= '0;
      in_col_q   <= '0;
      emit_row_q <= '0;
      emit_col_q <= '0;
      got_row_q  <= '0;
      got_col_q  <= '0;
    end else if (restart || (cmd_i.advance && last)) begin
      in_row_q   <= '0;
      in_col_q   <= '0;
      emit_row_q <= '0;
      emit_col_q <= '0;
      got_row_q  <= '0;
      got_col_q  <= '0;
    end else begin
      if (cmd_i.accept) begin
        got_row_q <= in_row_q;
        got_col_q <= in_col_q;
        if (in_col_q == d) begin
          in_col_q <= '0;
          in_row_q <= (in_row_q == d) ? '0 : in_row_q + CW'(1);
        end else begin
          in_col_q <= in_col_q + CW'(1);
        end
      end
      if (cmd_i.advance) begin
        if (emit_col_q == d) begin
          emit_col_q <= '0;
          emit_row_q <= emit_row_q + CW'(1);
        end else begin
          emit_col_q <= emit_col_q + CW'(1);
        end
      end
    end
  end

  // emit once the lower-right neighbor has arrived
  logic [CW-1:0] nr, nc;
  assign nr = (emit_row_q == d) ? d : emit_row_q + CW'(1);
  assign nc = (emit_col_q == d) ? d : emit_col_q + CW'(1);

  // neighbor address
  logic [PH_W-1:0] ph_q;
  logic [3:0]      off;
  logic [CW-1:0]   rr, cc;
  logic [AW-1:0]   wr_addr, rd_addr;

  assign off = nbr_off(ph_q);

  always_comb begin
    case (off[3:2])
      OFF_DEC: rr = (emit_row_q == '0) ? '0 : emit_row_q - CW'(1);
      OFF_INC: rr = nr;
      default: rr = emit_row_q;
    endcase
    case (off[1:0])
      OFF_DEC: cc = (emit_col_q == '0) ? '0 : emit_col_q - CW'(1);
      OFF_INC: cc = nc;
      default: cc = emit_col_q;
    endcase
  end

  assign wr_addr = AW'(in_row_q) * AW'(side) + AW'(in_col_q);
  assign rd_addr = AW'(rr) * AW'(side) + AW'(cc);

  logic [HEIGHT_BITS-1:0] mem [DEPTH];
  logic [HEIGHT_BITS-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mem[wr_addr] <= height_in_i;
    end
    rd_q <= mem[rd_addr];
  end

  // neighborhood sum and brush test, stepped by phase
  logic signed [SUM_W-1:0]       acc_q;
  logic signed [HEIGHT_BITS-1:0] old_q;
  logic signed [DR_W-1:0]        dr_q, dc_q, dr, dc;
  logic [SQ_W-1:0]               dr2_q, dc2_q;
  logic [S_W-1:0]                s_q;
  logic [63:0]                   a_q, b_q;
  logic [PL_W-1:0]               plo_q, phi_q;
  logic                          inside_q;
  logic [ST_W-1:0]               rstep, cstep;
  logic signed [2*DR_W-1:0]      dr_sq, dc_sq;
  logic [P_W-1:0]                prod;

  assign rstep = ST_W'(emit_row_q) << lod_q;
  assign cstep = ST_W'(emit_col_q) << lod_q;
  assign dr    = $signed({{(DR_W-17){crow_q[16]}}, crow_q}) -
                 $signed({{(DR_W-ST_W){1'b0}}, rstep});
  assign dc    = $signed({{(DR_W-17){ccol_q[16]}}, ccol_q}) -
                 $signed({{(DR_W-ST_W){1'b0}}, cstep});
  assign dr_sq = (2*DR_W)'(dr_q) * (2*DR_W)'(dr_q);
  assign dc_sq = (2*DR_W)'(dc_q) * (2*DR_W)'(dc_q);
  assign prod  = {phi_q, 32'b0} + P_W'(plo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= '0;
    end else if (cmd_i.emit_start) begin
      ph_q <= '0;
    end else if (cmd_i.ph_step) begin
      ph_q <= ph_q + PH_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_start) begin
      acc_q <= '0;
    end else if (cmd_i.ph_step) begin
      // read data trails the address by one phase
      if (ph_q != '0) begin
        acc_q <= acc_q + SUM_W'($signed(rd_q));
      end
      if (ph_q == PH_W'(5)) begin
        old_q <= rd_q;
      end
      case (ph_q)
        4'd0: begin
          dr_q <= dr;
          dc_q <= dc;
        end
        4'd1: begin
          dr2_q <= dr_sq[SQ_W-1:0];
          dc2_q <= dc_sq[SQ_W-1:0];
          a_q   <= 64'(vscale_q) * 64'(vscale_q);
        end
        4'd2: begin
          s_q <= S_W'(dr2_q) + S_W'(dc2_q);
          b_q <= 64'(radius_q) * 64'(radius_q);
        end
        4'd3: plo_q <= PL_W'(a_q[31:0]) * PL_W'(s_q);
        4'd4: phi_q <= PL_W'(a_q[63:32]) * PL_W'(s_q);
        4'd5: inside_q <= prod < P_W'(b_q);
        default: ;
      endcase
    end
  end

  // mean by reciprocal, blend
  logic                          neg;
  logic [SUM_W-2:0]              mag;
  logic [SUM_W-1:0]              abs_sum;
  logic [MP_W-1:0]               mprod;
  logic [HEIGHT_BITS-1:0]        q0_q, q;
  logic [SUM_W-1:0]              rem;
  logic signed [HEIGHT_BITS-1:0] mean_q, blend_q;
  logic [16:0]                   amt, inv;
  logic signed [T_W-1:0]         t1, t2, total;

  assign neg     = acc_q[SUM_W-1];
  assign abs_sum = neg ? SUM_W'(-acc_q) : SUM_W'(acc_q);
  assign mag     = abs_sum[SUM_W-2:0];
  assign mprod   = MP_W'(mag) * MP_W'(RECIP_W'(RECIP));
  assign rem     = SUM_W'(mag) - (SUM_W'({q0_q, 3'b0}) + SUM_W'(q0_q));
  assign q       = (rem >= SUM_W'(9)) ? q0_q + HEIGHT_BITS'(1) : q0_q;

  assign amt   = (amount_q > ONE) ? ONE : amount_q;
  assign inv   = ONE - amt;
  assign t1    = T_W'(mean_q) * T_W'($signed({1'b0, amt}));
  assign t2    = T_W'(old_q) * T_W'($signed({1'b0, inv}));
  assign total = t1 + t2;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div) begin
      q0_q <= mprod[DIV_SHIFT +: HEIGHT_BITS];
    end
    if (cmd_i.fix) begin
      mean_q <= neg ? -q : q;
    end
    if (cmd_i.blend) begin
      blend_q <= total[16 +: HEIGHT_BITS];
    end
  end

  // output register: frees the input side while a word waits
  logic                   out_full_q;
  logic [HEIGHT_BITS-1:0] out_height_q;
  logic [CW-1:0]          out_row_q, out_col_q;
  logic                   out_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_full_q <= 1'b0;
    end else if (cmd_i.advance) begin
      out_full_q <= 1'b1;
    end else if (out_ready_i) begin
      out_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.advance) begin
      out_height_q <= inside_q ? blend_q : old_q;
      out_row_q    <= emit_row_q;
      out_col_q    <= emit_col_q;
      out_done_q   <= last;
    end
  end

  assign out_valid_o   = out_full_q;
  assign height_out_o  = out_height_q;
  assign out_row_o     = out_row_q;
  assign out_col_o     = out_col_q;
  assign sector_done_o = out_done_q;

  assign status_o.emit_ok  = (nr < got_row_q) || ((nr == got_row_q) && (nc <= got_col_q));
  assign status_o.ph_last  = (ph_q == PH_W'(PH_LAST));
  assign status_o.last     = last;
  assign status_o.out_full = out_full_q;

endmodule

// ----- sv/masked_box_blur_3x3_core.sv -----
`timescale 1ns / 1ps
// Flow: the word that completes a neighborhood is accepted, then the check, the nine
// neighbor reads and the divide, fix-up and blend steps run before the result is offered;
// a word that completes no vertex frees the input after the check. No new word is taken
// until the core is idle again; the nine reads share the height store's one read port.
// Reset: rst_ni asynchronous active low; registers take their defaults, counters
// clear, the height store is not cleared.
module masked_box_blur_3x3_core import mbb_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [HEIGHT_BITS-1:0] height_in_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [HEIGHT_BITS-1:0] height_out_o,
  output logic [CW-1:0]          out_row_o,
  output logic [CW-1:0]          out_col_o,
  output logic                   sector_done_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  mbb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mbb_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .height_in_i   (height_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .height_out_o  (height_out_o),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .sector_done_o (sector_done_o),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule
